FILE: hw/rtl/rv32_exu_pkg.sv
// shared opcodes, constants and types for the rv32im execute unit
`default_nettype none
package rv32_exu_pkg;
   localparam int unsigned MemBytesDefault = 65536;

   localparam logic [5:0] OP_ADDI   = 6'd0;
   localparam logic [5:0] OP_ANDI   = 6'd1;
   localparam logic [5:0] OP_ORI    = 6'd2;
   localparam logic [5:0] OP_XORI   = 6'd3;
   localparam logic [5:0] OP_SLTI   = 6'd4;
   localparam logic [5:0] OP_SLTIU  = 6'd5;
   localparam logic [5:0] OP_SLLI   = 6'd6;
   localparam logic [5:0] OP_SRLI   = 6'd7;
   localparam logic [5:0] OP_SRAI   = 6'd8;
   localparam logic [5:0] OP_ADD    = 6'd9;
   localparam logic [5:0] OP_SUB    = 6'd10;
   localparam logic [5:0] OP_AND    = 6'd11;
   localparam logic [5:0] OP_OR     = 6'd12;
   localparam logic [5:0] OP_XOR    = 6'd13;
   localparam logic [5:0] OP_SLL    = 6'd14;
   localparam logic [5:0] OP_SRL    = 6'd15;
   localparam logic [5:0] OP_SRA    = 6'd16;
   localparam logic [5:0] OP_SLT    = 6'd17;
   localparam logic [5:0] OP_SLTU   = 6'd18;
   localparam logic [5:0] OP_BEQ    = 6'd19;
   localparam logic [5:0] OP_BNE    = 6'd20;
   localparam logic [5:0] OP_BLT    = 6'd21;
   localparam logic [5:0] OP_BLTU   = 6'd22;
   localparam logic [5:0] OP_BGE    = 6'd23;
   localparam logic [5:0] OP_BGEU   = 6'd24;
   localparam logic [5:0] OP_JAL    = 6'd25;
   localparam logic [5:0] OP_JALR   = 6'd26;
   localparam logic [5:0] OP_LB     = 6'd27;
   localparam logic [5:0] OP_LBU    = 6'd28;
   localparam logic [5:0] OP_LH     = 6'd29;
   localparam logic [5:0] OP_LHU    = 6'd30;
   localparam logic [5:0] OP_LW     = 6'd31;
   localparam logic [5:0] OP_SB     = 6'd32;
   localparam logic [5:0] OP_SH     = 6'd33;
   localparam logic [5:0] OP_SW     = 6'd34;
   localparam logic [5:0] OP_AUIPC  = 6'd35;
   localparam logic [5:0] OP_LUI    = 6'd36;
   localparam logic [5:0] OP_MUL    = 6'd37;
   localparam logic [5:0] OP_MULH   = 6'd38;
   localparam logic [5:0] OP_MULHU  = 6'd39;
   localparam logic [5:0] OP_MULHSU = 6'd40;
   localparam logic [5:0] OP_DIV    = 6'd41;
   localparam logic [5:0] OP_DIVU   = 6'd42;
   localparam logic [5:0] OP_REM    = 6'd43;
   localparam logic [5:0] OP_REMU   = 6'd44;
   localparam logic [5:0] OP_UNKNOWN = 6'd47;

   localparam logic [31:0] JALR_MASK  = 32'hFFFF_FFFE;
   localparam logic [31:0] SEXT_B     = 32'hFFFF_FF00;
   localparam logic [31:0] SEXT_H     = 32'hFFFF_0000;
   localparam logic [31:0] SIGN_B     = 32'h0000_0080;
   localparam logic [31:0] SIGN_H     = 32'h0000_8000;

   // request to the shared multiply/divide unit
   typedef struct packed {
      logic        start;
      logic        is_div;
      logic        a_signed;
      logic        b_signed;
      logic        want_high;  // mul: high word; div: remainder
      logic [31:0] a;
      logic [31:0] b;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } md_rsp_type;
endpackage
`default_nettype wire

FILE: hw/rtl/rv32_exu_muldiv.sv
// iterative shared multiply/divide unit, one bit per cycle
`default_nettype none
module rv32_exu_muldiv (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rv32_exu_pkg::md_req_type req,
   output rv32_exu_pkg::md_rsp_type      rsp
);
   logic        busy_ff, busy_in;
   logic [5:0]  count_ff, count_in;
   logic        is_div_ff, is_div_in;
   logic        high_ff, high_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic [31:0] a_ff, a_in;         // raw dividend or multiplier
   logic [31:0] b_ff, b_in;         // divisor or multiplicand magnitude
   logic [63:0] acc_ff, acc_in;     // product or {rem, quotient}
   logic        a_neg_ff, a_neg_in;
   logic        done_ff, done_in;
   logic [31:0] res_ff, res_in;

   logic        a_neg, b_neg;
   logic [31:0] a_mag, b_mag;
   logic [32:0] psum;
   logic [32:0] trial;
   logic [31:0] rem_next;
   logic [63:0] prod_neg;
   logic [31:0] q_fix, r_fix;

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

   always_comb begin
      a_neg = req.a_signed & req.a[31];
      b_neg = req.b_signed & req.b[31];
      a_mag = a_neg ? (32'd0 - req.a) : req.a;
      b_mag = b_neg ? (32'd0 - req.b) : req.b;
      // multiply step: add multiplicand to high half, shift right
      psum  = {1'b0, acc_ff[63:32]} + (a_ff[0] ? {1'b0, b_ff} : 33'd0);
      // restoring divide step on {rem, dividend}
      trial = {acc_ff[63:32], acc_ff[31]} - {1'b0, b_ff};
      rem_next = trial[32] ? {acc_ff[62:31]} : trial[31:0];
      prod_neg = 64'd0 - acc_ff;
      q_fix = neg_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
      r_fix = a_neg_ff ? (32'd0 - acc_ff[63:32]) : acc_ff[63:32];
   end

   always_comb begin
      busy_in = busy_ff;
      count_in = count_ff;
      is_div_in = is_div_ff;
      high_in = high_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      a_neg_in = a_neg_ff;
      done_in = 1'b0;
      res_in = res_ff;
      if (req.start) begin
         busy_in = 1'b1;
         count_in = 6'd32;
         is_div_in = req.is_div;
         high_in = req.want_high;
         neg_in = a_neg ^ b_neg;
         zero_in = (req.b == 32'd0);
         a_in = req.is_div ? req.a : a_mag;
         b_in = b_mag;
         acc_in = req.is_div ? {32'd0, a_mag} : 64'd0;
         a_neg_in = a_neg;
      end else if (busy_ff) begin
         if (count_ff != 6'd0) begin
            count_in = count_ff - 6'd1;
            if (is_div_ff) begin
               acc_in = {rem_next, acc_ff[30:0], ~trial[32]};
            end else begin
               acc_in = {psum, acc_ff[31:1]};
               a_in = {1'b0, a_ff[31:1]};
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (is_div_ff) begin
               if (zero_ff)
                  res_in = high_ff ? a_ff : 32'hFFFF_FFFF;
               else
                  res_in = high_ff ? r_fix : q_fix;
            end else begin
               if (neg_ff)
                  res_in = high_ff ? prod_neg[63:32] : prod_neg[31:0];
               else
                  res_in = high_ff ? acc_ff[63:32] : acc_ff[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      is_div_ff <= is_div_in;
      high_ff <= high_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      a_neg_ff <= a_neg_in;
      res_ff <= res_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/rv32im_execute_unit.sv
// top level of the rv32im execute unit: sequencer, register file, data memory
//
//  channel | ports                           | direction
//  request | req_valid/req_ready + 6 fields  | in
//  result  | rsp_valid/rsp_ready + 6 fields  | out
//
// after reset a clearing pass writes zero to every memory byte with req_ready low.
// from accept to rsp_valid, alu, branch and jump ops pass operand read, execute and
// write-back; halting ops and items after a halt skip write-back; stores add an
// address step per byte, loads an address step and a registered read per byte, and
// mul/div wait on the shared bit-serial unit. a stalled result holds the block;
// req_ready returns in the cycle after the result beat.
`default_nettype none
module rv32im_execute_unit #(
   parameter int unsigned MEM_BYTES = rv32_exu_pkg::MemBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [5:0]  req_command,
   input  wire logic [4:0]  req_dest_reg,
   input  wire logic [4:0]  req_src1_reg,
   input  wire logic [4:0]  req_src2_reg,
   input  wire logic [31:0] req_immediate,
   input  wire logic [4:0]  req_shift_amount,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_written_index,
   output logic [31:0]      rsp_written_value,
   output logic             rsp_halted_now,
   output logic             rsp_unknown_op
);
   localparam int unsigned AW = $clog2(MEM_BYTES);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MEM_ADDR, ST_MEM_DATA,
      ST_MD_WAIT, ST_DONE, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [AW:0] clr_ff;
   logic [31:0] regs_ff [32];
   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  rdata_ff;

   logic [31:0] pc_ff;
   logic        stop_ff;
   logic [5:0]  cmd_ff;
   logic [4:0]  rd_ff;
   logic [4:0]  rs1_ff, rs2_ff;
   logic [31:0] imm_ff;
   logic [4:0]  sh_ff;
   logic [31:0] a_ff, b_ff;
   logic [31:0] val_ff;
   logic        wr_ff;
   logic [31:0] npc_ff;
   logic [31:0] addr_ff;
   logic [2:0]  nbytes_ff;
   logic [1:0]  k_ff;
   logic        is_store_ff;
   logic        unk_ff;

   rv32_exu_pkg::md_req_type md_req;
   rv32_exu_pkg::md_rsp_type md_rsp;

   rv32_exu_muldiv u_md (.clock(clock), .reset(reset), .req(md_req), .rsp(md_rsp));

   // combinational execute of simple ops
   logic [31:0] alu_val;
   logic        alu_wr;
   logic [31:0] alu_npc;
   logic        is_mem, is_md, is_halt;
   logic [31:0] sum_ai;
   logic        lt_s, lt_u;
   logic [31:0] byte_addr;
   logic [31:0] ld_val;

   always_comb begin
      sum_ai = a_ff + imm_ff;
      lt_s = $signed(a_ff) < $signed(b_ff);
      lt_u = a_ff < b_ff;
      alu_val = 32'd0;
      alu_wr = 1'b1;
      alu_npc = pc_ff + 32'd4;
      is_mem = 1'b0;
      is_md = 1'b0;
      is_halt = 1'b0;
      case (cmd_ff)
         rv32_exu_pkg::OP_ADDI:  alu_val = sum_ai;
         rv32_exu_pkg::OP_ANDI:  alu_val = a_ff & imm_ff;
         rv32_exu_pkg::OP_ORI:   alu_val = a_ff | imm_ff;
         rv32_exu_pkg::OP_XORI:  alu_val = a_ff ^ imm_ff;
         rv32_exu_pkg::OP_SLTI:  alu_val = {31'd0, $signed(a_ff) < $signed(imm_ff)};
         rv32_exu_pkg::OP_SLTIU: alu_val = {31'd0, a_ff < imm_ff};
         rv32_exu_pkg::OP_SLLI:  alu_val = a_ff << sh_ff;
         rv32_exu_pkg::OP_SRLI:  alu_val = a_ff >> sh_ff;
         rv32_exu_pkg::OP_SRAI:  alu_val = 32'($signed(a_ff) >>> sh_ff);
         rv32_exu_pkg::OP_ADD:   alu_val = a_ff + b_ff;
         rv32_exu_pkg::OP_SUB:   alu_val = a_ff - b_ff;
         rv32_exu_pkg::OP_AND:   alu_val = a_ff & b_ff;
         rv32_exu_pkg::OP_OR:    alu_val = a_ff | b_ff;
         rv32_exu_pkg::OP_XOR:   alu_val = a_ff ^ b_ff;
         rv32_exu_pkg::OP_SLL:   alu_val = a_ff << b_ff[4:0];
         rv32_exu_pkg::OP_SRL:   alu_val = a_ff >> b_ff[4:0];
         rv32_exu_pkg::OP_SRA:   alu_val = 32'($signed(a_ff) >>> b_ff[4:0]);
         rv32_exu_pkg::OP_SLT:   alu_val = {31'd0, lt_s};
         rv32_exu_pkg::OP_SLTU:  alu_val = {31'd0, lt_u};
         rv32_exu_pkg::OP_BEQ: begin
            alu_wr = 1'b0;
            if (a_ff == b_ff) alu_npc = pc_ff + imm_ff;
         end
         rv32_exu_pkg::OP_BNE: begin
            alu_wr = 1'b0;
            if (a_ff != b_ff) alu_npc = pc_ff + imm_ff;
         end
         rv32_exu_pkg::OP_BLT: begin
            alu_wr = 1'b0;
            if (lt_s) alu_npc = pc_ff + imm_ff;
         end
         rv32_exu_pkg::OP_BLTU: begin
            alu_wr = 1'b0;
            if (lt_u) alu_npc = pc_ff + imm_ff;
         end
         rv32_exu_pkg::OP_BGE: begin
            alu_wr = 1'b0;
            if (!lt_s) alu_npc = pc_ff + imm_ff;
         end
         rv32_exu_pkg::OP_BGEU: begin
            alu_wr = 1'b0;
            if (!lt_u) alu_npc = pc_ff + imm_ff;
         end
         rv32_exu_pkg::OP_JAL: begin
            alu_val = pc_ff + 32'd4;
            alu_npc = pc_ff + imm_ff;
         end
         rv32_exu_pkg::OP_JALR: begin
            alu_val = pc_ff + 32'd4;
            alu_npc = sum_ai & rv32_exu_pkg::JALR_MASK;
         end
         rv32_exu_pkg::OP_LB, rv32_exu_pkg::OP_LBU, rv32_exu_pkg::OP_LH,
         rv32_exu_pkg::OP_LHU, rv32_exu_pkg::OP_LW: is_mem = 1'b1;
         rv32_exu_pkg::OP_SB, rv32_exu_pkg::OP_SH, rv32_exu_pkg::OP_SW: begin
            is_mem = 1'b1;
            alu_wr = 1'b0;
         end
         rv32_exu_pkg::OP_AUIPC: alu_val = pc_ff + imm_ff;
         rv32_exu_pkg::OP_LUI:   alu_val = imm_ff;
         rv32_exu_pkg::OP_MUL, rv32_exu_pkg::OP_MULH, rv32_exu_pkg::OP_MULHU,
         rv32_exu_pkg::OP_MULHSU, rv32_exu_pkg::OP_DIV, rv32_exu_pkg::OP_DIVU,
         rv32_exu_pkg::OP_REM, rv32_exu_pkg::OP_REMU: is_md = 1'b1;
         default: begin
            alu_wr = 1'b0;
            is_halt = 1'b1;
         end
      endcase
   end

   always_comb begin
      md_req.start = (state_ff == ST_EXEC) && !stop_ff && is_md;
      md_req.is_div = (cmd_ff inside {rv32_exu_pkg::OP_DIV, rv32_exu_pkg::OP_DIVU,
                                      rv32_exu_pkg::OP_REM, rv32_exu_pkg::OP_REMU});
      md_req.a_signed = (cmd_ff inside {rv32_exu_pkg::OP_MULH, rv32_exu_pkg::OP_MULHSU,
                                        rv32_exu_pkg::OP_DIV, rv32_exu_pkg::OP_REM});
      md_req.b_signed = (cmd_ff inside {rv32_exu_pkg::OP_MULH, rv32_exu_pkg::OP_DIV,
                                        rv32_exu_pkg::OP_REM});
      md_req.want_high = (cmd_ff inside {rv32_exu_pkg::OP_MULH, rv32_exu_pkg::OP_MULHU,
                                         rv32_exu_pkg::OP_MULHSU, rv32_exu_pkg::OP_REM,
                                         rv32_exu_pkg::OP_REMU});
      md_req.a = a_ff;
      md_req.b = b_ff;
      byte_addr = addr_ff + {30'd0, k_ff};
      // take the assembled load bytes, then sign or zero extend
      ld_val = val_ff;
      case (cmd_ff)
         rv32_exu_pkg::OP_LB:
            ld_val = ((val_ff & rv32_exu_pkg::SIGN_B) != 32'd0) ?
                     (val_ff | rv32_exu_pkg::SEXT_B) : val_ff;
         rv32_exu_pkg::OP_LH:
            ld_val = ((val_ff & rv32_exu_pkg::SIGN_H) != 32'd0) ?
                     (val_ff | rv32_exu_pkg::SEXT_H) : val_ff;
         default: ld_val = val_ff;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_next_pc = pc_ff;
   assign rsp_reg_written = wr_ff;
   assign rsp_written_index = wr_ff ? rd_ff : 5'd0;
   assign rsp_written_value = wr_ff ? val_ff : 32'd0;
   assign rsp_halted_now = stop_ff;
   assign rsp_unknown_op = unk_ff;

   // memory: clear pass, byte store, registered byte read
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR)
         mem[clr_ff[AW-1:0]] <= 8'd0;
      else if (state_ff == ST_MEM_ADDR && is_store_ff)
         mem[AW'(byte_addr % MEM_BYTES)] <= 8'(b_ff >> {k_ff, 3'b000});
      rdata_ff <= mem[AW'(byte_addr % MEM_BYTES)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         pc_ff <= 32'd0;
         stop_ff <= 1'b0;
         wr_ff <= 1'b0;
         unk_ff <= 1'b0;
         for (int i = 0; i < 32; i++) regs_ff[i] <= 32'd0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(MEM_BYTES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_command;
                  rd_ff <= req_dest_reg;
                  rs1_ff <= req_src1_reg;
                  rs2_ff <= req_src2_reg;
                  imm_ff <= req_immediate;
                  sh_ff <= req_shift_amount;
                  unk_ff <= (req_command >= rv32_exu_pkg::OP_UNKNOWN);
                  wr_ff <= 1'b0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               a_ff <= regs_ff[rs1_ff];
               b_ff <= regs_ff[rs2_ff];
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (stop_ff) begin
                  state_ff <= ST_OUT;
               end else if (is_halt) begin
                  stop_ff <= 1'b1;
                  pc_ff <= pc_ff + 32'd4;
                  state_ff <= ST_OUT;
               end else if (is_md) begin
                  npc_ff <= pc_ff + 32'd4;
                  state_ff <= ST_MD_WAIT;
               end else if (is_mem) begin
                  npc_ff <= pc_ff + 32'd4;
                  addr_ff <= sum_ai;
                  k_ff <= 2'd0;
                  val_ff <= 32'd0;
                  is_store_ff <= !alu_wr;
                  nbytes_ff <= (cmd_ff inside {rv32_exu_pkg::OP_LW, rv32_exu_pkg::OP_SW}) ?
                     3'd4 : (cmd_ff inside {rv32_exu_pkg::OP_LH, rv32_exu_pkg::OP_LHU,
                                            rv32_exu_pkg::OP_SH}) ? 3'd2 : 3'd1;
                  state_ff <= ST_MEM_ADDR;
               end else begin
                  val_ff <= alu_val;
                  wr_ff <= alu_wr;
                  npc_ff <= alu_npc;
                  state_ff <= ST_DONE;
               end
            end
            ST_MEM_ADDR: begin
               if (is_store_ff) begin
                  if ({1'b0, k_ff} == nbytes_ff - 3'd1) state_ff <= ST_DONE;
                  k_ff <= k_ff + 2'd1;
               end else begin
                  state_ff <= ST_MEM_DATA;
               end
            end
            ST_MEM_DATA: begin
               // read byte lands in the cycle after its address
               val_ff <= val_ff | ({24'd0, rdata_ff} << {k_ff, 3'b000});
               k_ff <= k_ff + 2'd1;
               if ({1'b0, k_ff} == nbytes_ff - 3'd1) begin
                  wr_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_MEM_ADDR;
               end
            end
            ST_MD_WAIT: begin
               if (md_rsp.done) begin
                  val_ff <= md_rsp.result;
                  wr_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (is_mem && wr_ff) val_ff <= ld_val;
               if (wr_ff && rd_ff != 5'd0)
                  regs_ff[rd_ff] <= (is_mem ? ld_val : val_ff);
               else
                  wr_ff <= 1'b0;
               pc_ff <= npc_ff;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: tb/sv/rv32im_execute_checker.sv
// checker for the rv32im execute unit: watches both channels, predicts and compares results
module rv32im_execute_checker #(
   parameter int unsigned MEM_BYTES = rv32_exu_pkg::MemBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [5:0]  req_command,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src1_reg,
   input  logic [4:0]  req_src2_reg,
   input  logic [31:0] req_immediate,
   input  logic [4:0]  req_shift_amount,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_next_pc,
   input  logic        rsp_reg_written,
   input  logic [4:0]  rsp_written_index,
   input  logic [31:0] rsp_written_value,
   input  logic        rsp_halted_now,
   input  logic        rsp_unknown_op,
   output int          fail_count,
   output int          outstanding,
   output int          retired
);
   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  written_index;
      logic [31:0] written_value;
      logic        halted_now;
      logic        unknown_op;
   } exec_result_type;

   logic [31:0] arch_regs [32];
   logic [31:0] arch_pc;
   logic        arch_halted;
   logic [7:0]  data_mem [MEM_BYTES];
   exec_result_type pending_results[$];

   initial begin
      fail_count = 0;
      retired = 0;
      outstanding = 0;
      arch_pc = '0;
      arch_halted = 1'b0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
   end

   function automatic logic [31:0] mem_read(logic [31:0] base, int nbytes);
      logic [31:0] v;
      logic [31:0] at;
      v = '0;
      for (int k = 0; k < nbytes; k++) begin
         at = base + 32'(k);
         v[8*k +: 8] = data_mem[at % MEM_BYTES];
      end
      return v;
   endfunction

   task automatic mem_write(logic [31:0] base, int nbytes, logic [31:0] v);
      logic [31:0] at;
      for (int k = 0; k < nbytes; k++) begin
         at = base + 32'(k);
         data_mem[at % MEM_BYTES] = v[8*k +: 8];
      end
   endtask

   // advances the architectural copy by one instruction, unless halted, and returns the write-back
   task automatic execute_instr(logic [5:0] cmd, logic [4:0] rd, logic [4:0] rs1,
                                logic [4:0] rs2, logic [31:0] imm, logic [4:0] sh,
                                output exec_result_type r);
      logic [31:0] a, b, val, npc, addr, t, qa, qb;
      logic [63:0] prod;
      logic        wr;
      a = arch_regs[rs1];
      b = arch_regs[rs2];
      val = '0;
      wr = 1'b0;
      if (!arch_halted) begin
         npc = arch_pc + 32'd4;
         addr = a + imm;
         wr = 1'b1;
         case (cmd)
            rv32_exu_pkg::OP_ADDI: val = a + imm;
            rv32_exu_pkg::OP_ANDI: val = a & imm;
            rv32_exu_pkg::OP_ORI: val = a | imm;
            rv32_exu_pkg::OP_XORI: val = a ^ imm;
            rv32_exu_pkg::OP_SLTI: val = {31'b0, $signed(a) < $signed(imm)};
            rv32_exu_pkg::OP_SLTIU: val = {31'b0, a < imm};
            rv32_exu_pkg::OP_SLLI: val = a << sh;
            rv32_exu_pkg::OP_SRLI: val = a >> sh;
            rv32_exu_pkg::OP_SRAI: val = 32'($signed(a) >>> sh);
            rv32_exu_pkg::OP_ADD: val = a + b;
            rv32_exu_pkg::OP_SUB: val = a - b;
            rv32_exu_pkg::OP_AND: val = a & b;
            rv32_exu_pkg::OP_OR: val = a | b;
            rv32_exu_pkg::OP_XOR: val = a ^ b;
            rv32_exu_pkg::OP_SLL: val = a << b[4:0];
            rv32_exu_pkg::OP_SRL: val = a >> b[4:0];
            rv32_exu_pkg::OP_SRA: val = 32'($signed(a) >>> b[4:0]);
            rv32_exu_pkg::OP_SLT: val = {31'b0, $signed(a) < $signed(b)};
            rv32_exu_pkg::OP_SLTU: val = {31'b0, a < b};
            rv32_exu_pkg::OP_BEQ: begin
               wr = 1'b0;
               if (a == b) npc = arch_pc + imm;
            end
            rv32_exu_pkg::OP_BNE: begin
               wr = 1'b0;
               if (a != b) npc = arch_pc + imm;
            end
            rv32_exu_pkg::OP_BLT: begin
               wr = 1'b0;
               if ($signed(a) < $signed(b)) npc = arch_pc + imm;
            end
            rv32_exu_pkg::OP_BLTU: begin
               wr = 1'b0;
               if (a < b) npc = arch_pc + imm;
            end
            rv32_exu_pkg::OP_BGE: begin
               wr = 1'b0;
               if ($signed(a) >= $signed(b)) npc = arch_pc + imm;
            end
            rv32_exu_pkg::OP_BGEU: begin
               wr = 1'b0;
               if (a >= b) npc = arch_pc + imm;
            end
            rv32_exu_pkg::OP_JAL: begin
               val = arch_pc + 32'd4;
               npc = arch_pc + imm;
            end
            rv32_exu_pkg::OP_JALR: begin
               val = arch_pc + 32'd4;
               npc = (a + imm) & rv32_exu_pkg::JALR_MASK;
            end
            rv32_exu_pkg::OP_LB: begin
               t = mem_read(addr, 1);
               val = (t & rv32_exu_pkg::SIGN_B) != 32'd0 ? (t | rv32_exu_pkg::SEXT_B) : t;
            end
            rv32_exu_pkg::OP_LBU: val = mem_read(addr, 1);
            rv32_exu_pkg::OP_LH: begin
               t = mem_read(addr, 2);
               val = (t & rv32_exu_pkg::SIGN_H) != 32'd0 ? (t | rv32_exu_pkg::SEXT_H) : t;
            end
            rv32_exu_pkg::OP_LHU: val = mem_read(addr, 2);
            rv32_exu_pkg::OP_LW: val = mem_read(addr, 4);
            rv32_exu_pkg::OP_SB: begin wr = 1'b0; mem_write(addr, 1, b); end
            rv32_exu_pkg::OP_SH: begin wr = 1'b0; mem_write(addr, 2, b); end
            rv32_exu_pkg::OP_SW: begin wr = 1'b0; mem_write(addr, 4, b); end
            rv32_exu_pkg::OP_AUIPC: val = arch_pc + imm;
            rv32_exu_pkg::OP_LUI: val = imm;
            rv32_exu_pkg::OP_MUL: val = a * b;
            rv32_exu_pkg::OP_MULH: begin
               prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
               val = prod[63:32];
            end
            rv32_exu_pkg::OP_MULHU: begin
               prod = {32'b0, a} * {32'b0, b};
               val = prod[63:32];
            end
            rv32_exu_pkg::OP_MULHSU: begin
               prod = {{32{a[31]}}, a} * {32'b0, b};
               val = prod[63:32];
            end
            rv32_exu_pkg::OP_DIV, rv32_exu_pkg::OP_REM: begin
               // magnitudes keep the most negative dividend out of signed overflow
               qa = a[31] ? -a : a;
               qb = b[31] ? -b : b;
               if (b == 32'd0) val = (cmd == rv32_exu_pkg::OP_DIV) ? 32'hFFFF_FFFF : a;
               else if (cmd == rv32_exu_pkg::OP_DIV) begin
                  val = qa / qb;
                  if (a[31] ^ b[31]) val = -val;
               end else begin
                  val = qa % qb;
                  if (a[31]) val = -val;
               end
            end
            rv32_exu_pkg::OP_DIVU: val = (b == 32'd0) ? 32'hFFFF_FFFF : a / b;
            rv32_exu_pkg::OP_REMU: val = (b == 32'd0) ? a : a % b;
            default: begin
               wr = 1'b0;
               arch_halted = 1'b1;
            end
         endcase
         if (wr && rd != 5'd0) arch_regs[rd] = val;
         else wr = 1'b0;
         arch_pc = npc;
      end
      r.next_pc = arch_pc;
      r.reg_written = wr;
      r.written_index = wr ? rd : 5'd0;
      r.written_value = wr ? val : 32'd0;
      r.halted_now = arch_halted;
      r.unknown_op = cmd >= rv32_exu_pkg::OP_UNKNOWN;
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      exec_result_type r, e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected, next_pc %h", rsp_next_pc);
               fail_count++;
            end else begin
               e = pending_results.pop_front();
               check_field("next_pc", e.next_pc, rsp_next_pc);
               check_field("reg_written", 32'(e.reg_written), 32'(rsp_reg_written));
               check_field("written_index", 32'(e.written_index), 32'(rsp_written_index));
               check_field("written_value", e.written_value, rsp_written_value);
               check_field("halted_now", 32'(e.halted_now), 32'(rsp_halted_now));
               check_field("unknown_op", 32'(e.unknown_op), 32'(rsp_unknown_op));
               retired++;
            end
         end
         if (req_valid && req_ready) begin
            execute_instr(req_command, req_dest_reg, req_src1_reg, req_src2_reg,
                          req_immediate, req_shift_amount, r);
            pending_results.push_back(r);
         end
         outstanding = pending_results.size();
      end
   end
endmodule

FILE: tb/sv/tb_rv32im_execute_unit.sv
// testbench top for the rv32im execute unit: clock, reset, instruction stimulus, verdict
module tb_rv32im_execute_unit;
   localparam int CycleLimit = 1_000_000;
   localparam int RandomItems = 1600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [5:0]  req_command = '0;
   logic [4:0]  req_dest_reg = '0;
   logic [4:0]  req_src1_reg = '0;
   logic [4:0]  req_src2_reg = '0;
   logic [31:0] req_immediate = '0;
   logic [4:0]  req_shift_amount = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_reg_written;
   logic [4:0]  rsp_written_index;
   logic [31:0] rsp_written_value;
   logic        rsp_halted_now;
   logic        rsp_unknown_op;

   int fail_count, outstanding, retired;
   int send_idle_pct = 25;
   int recv_stall_pct = 51;
   int sent_count = 0;
   int cycle_count = 0;
   logic hold_off = 1'b0;

   rv32im_execute_unit dut (.*);

   rv32im_execute_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (sent_count >= 1200);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (400) @(negedge clock);
      hold_off = 1'b0;
   end

   task automatic issue_instr(logic [5:0] cmd, logic [4:0] rd, logic [4:0] rs1,
                              logic [4:0] rs2, logic [31:0] imm, logic [4:0] sh);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_command = cmd;
      req_dest_reg = rd;
      req_src1_reg = rs1;
      req_src2_reg = rs2;
      req_immediate = imm;
      req_shift_amount = sh;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_imm();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'($signed($urandom_range(128)) - 64);
      endcase
   endfunction

   function automatic logic [5:0] pick_op();
      // loads and stores biased up so memory contents get reused
      case ($urandom_range(9))
         0, 1: return 6'($urandom_range(rv32_exu_pkg::OP_SLTU));
         2: return 6'($urandom_range(rv32_exu_pkg::OP_BGEU, rv32_exu_pkg::OP_BEQ));
         3: return ($urandom_range(1) != 0) ? rv32_exu_pkg::OP_JAL : rv32_exu_pkg::OP_JALR;
         4, 5: return 6'($urandom_range(rv32_exu_pkg::OP_SW, rv32_exu_pkg::OP_LB));
         6: return ($urandom_range(1) != 0) ? rv32_exu_pkg::OP_LUI : rv32_exu_pkg::OP_AUIPC;
         default: return 6'($urandom_range(rv32_exu_pkg::OP_REMU, rv32_exu_pkg::OP_MUL));
      endcase
   endfunction

   task automatic random_instr();
      logic [5:0]  op;
      logic [4:0]  rs1;
      logic [31:0] imm;
      op = pick_op();
      rs1 = 5'($urandom);
      imm = pick_imm();
      // keep most memory traffic in a small window so stores get read back
      if (op >= rv32_exu_pkg::OP_LB && op <= rv32_exu_pkg::OP_SW &&
          $urandom_range(3) != 0) begin
         rs1 = 5'd0;
         imm = $urandom_range(63);
      end
      issue_instr(op, 5'($urandom), rs1, 5'($urandom), imm, 5'($urandom));
   endtask

   initial begin
      logic [5:0] halt_op;
      @(negedge clock);
      wait (!reset);
      @(negedge clock);

      // operand setup and the corner cases: overflow, divide by zero, x0, wraps
      issue_instr(rv32_exu_pkg::OP_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000, 5'd0);
      issue_instr(rv32_exu_pkg::OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, 5'd0);
      issue_instr(rv32_exu_pkg::OP_DIV, 5'd3, 5'd1, 5'd2, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_REM, 5'd4, 5'd1, 5'd2, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_DIV, 5'd5, 5'd1, 5'd0, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_DIVU, 5'd6, 5'd2, 5'd0, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_REM, 5'd7, 5'd1, 5'd0, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_REMU, 5'd8, 5'd2, 5'd0, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_ADDI, 5'd0, 5'd2, 5'd0, 32'h7FFF_FFFF, 5'd0);
      issue_instr(rv32_exu_pkg::OP_SLL, 5'd9, 5'd2, 5'd2, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_SRA, 5'd10, 5'd1, 5'd2, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_SRAI, 5'd11, 5'd1, 5'd0, 32'd0, 5'd31);
      issue_instr(rv32_exu_pkg::OP_SW, 5'd0, 5'd0, 5'd1, 32'hFFFF_FFFE, 5'd0);
      issue_instr(rv32_exu_pkg::OP_LW, 5'd12, 5'd0, 5'd0, 32'hFFFF_FFFE, 5'd0);
      issue_instr(rv32_exu_pkg::OP_LB, 5'd13, 5'd0, 5'd0, 32'hFFFF_FFFF, 5'd0);
      issue_instr(rv32_exu_pkg::OP_LHU, 5'd14, 5'd0, 5'd0, 32'd1, 5'd0);
      issue_instr(rv32_exu_pkg::OP_MULH, 5'd15, 5'd1, 5'd1, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_MULHSU, 5'd16, 5'd1, 5'd2, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_MULHU, 5'd17, 5'd2, 5'd2, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_JALR, 5'd18, 5'd2, 5'd0, 32'h0000_0103, 5'd0);
      issue_instr(rv32_exu_pkg::OP_JAL, 5'd31, 5'd0, 5'd0, 32'h8000_0000, 5'd0);
      issue_instr(rv32_exu_pkg::OP_AUIPC, 5'd19, 5'd0, 5'd0, 32'h7FFF_F000, 5'd0);
      issue_instr(rv32_exu_pkg::OP_BLT, 5'd0, 5'd1, 5'd2, 32'hFFFF_FFF0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_BGEU, 5'd0, 5'd2, 5'd1, 32'd8, 5'd0);

      for (int i = 0; i < RandomItems; i++) begin
         if (i == RandomItems / 3) begin
            send_idle_pct = 51;
            recv_stall_pct = 25;
         end else if (i == 2 * RandomItems / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         random_instr();
      end

      // one halting op stops the core; everything after must leave state alone
      halt_op = 6'($urandom_range(63, 45));
      issue_instr(halt_op, 5'd1, 5'd1, 5'd2, 32'd4, 5'd0);
      for (int c = 45; c < 64; c++)
         issue_instr(6'(c), 5'($urandom), 5'($urandom), 5'($urandom), $urandom, 5'($urandom));
      issue_instr(rv32_exu_pkg::OP_ADDI, 5'd1, 5'd0, 5'd0, 32'd1, 5'd0);
      issue_instr(rv32_exu_pkg::OP_SW, 5'd0, 5'd0, 5'd2, 32'd0, 5'd0);
      issue_instr(rv32_exu_pkg::OP_LW, 5'd3, 5'd0, 5'd0, 32'd0, 5'd0);
      req_valid = 1'b0;

      wait (outstanding == 0);
      repeat (100) @(posedge clock);
      $display("sent %0d instructions, %0d results checked across all ops,",
               sent_count, retired);
      $display("three idle mixes, a long output hold-off and a halt ending");
      if (fail_count == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
